/* rtl/sha256_pkg.sv */
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants, initial hash values and sigma functions
// for the SHA-256 message hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumH   = 8;
  localparam int unsigned BlockW = 512;
  localparam int unsigned CountW = 61;

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumH-1:0][WordW-1:0] hash_arr_t;

  localparam logic [7:0] PadMark   = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] LastSlot  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t init_h(logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic hash_arr_t init_hash();
    hash_arr_t r;
    for (int i = 0; i < NumH; i++) begin
      r[i] = init_h(3'(i));
    end
    return r;
  endfunction

  function automatic word_t round_k(logic [5:0] idx);
    word_t r;
    case (idx)
      6'd0:  r = 32'h428a2f98;
      6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;
      6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;
      6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;
      6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;
      6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;
      6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;
      6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;
      6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;
      6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;
      6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;
      6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;
      6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;
      6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;
      6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;
      6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;
      6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;
      6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;
      6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;
      6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;
      6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;
      6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      6'd63: r = 32'hc67178f2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/sha256_message_hasher_unit.sv */
// ----------------------------------------------------------------------------
// sha256_message_hasher_unit
// SHA-256 hasher for a byte stream: packs bytes into 512-bit blocks, pads on
// end of message and returns the eight digest words.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | has_byte, message_byte, end_of_message
//   out     | output    | out_valid/out_ready | word_index, digest_word, last_word
//
// each byte transfer fills one slot; a full block starts the 64 rounds of
// the shared round unit and a fold into the hash, taking no bytes meanwhile;
// end of message inserts padding one byte per cycle, pausing while a block is hashed
// (up to two more blocks), then offers eight digest words, one per out transfer
// reset loads the initial hash values; no clearing pass is needed
// in_ready is low during padding, rounds, the fold and digest output; an out stall
// holds the current word
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        has_byte_i,
  input  logic [7:0]  message_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  word_index_o,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_ADD,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    P_MARK,
    P_ZERO_WRAP,
    P_ZERO_LEN
  } pad_e;

  state_e state_q, state_d;
  pad_e   phase_q, phase_d;
  logic   pad_act_q, pad_act_d;
  logic   pad_done_q, pad_done_d;
  logic [5:0] fill_q, fill_d;
  logic [5:0] round_q, round_d;
  logic [2:0] idx_q, idx_d;
  logic [sha256_pkg::CountW-1:0] count_q, count_d;
  sha256_pkg::hash_arr_t hash_q, hash_d;
  sha256_pkg::hash_arr_t vars_q, vars_d;
  logic [sha256_pkg::BlockW-1:0] blk_q, blk_d;

  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  pad_byte;
  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  sha256_pkg::word_t w_cur, w_new, t1, t2, ch, maj;

  assign bit_len = {count_q, 3'b000};
  assign len_sel = 3'd7 - fill_q[2:0];

  always_comb begin
    case (phase_q)
      P_MARK:     pad_byte = sha256_pkg::PadMark;
      P_ZERO_LEN: pad_byte = (fill_q >= sha256_pkg::LenStart)
                             ? bit_len[{len_sel, 3'b000} +: 8] : 8'h00;
      default:    pad_byte = 8'h00;
    endcase
  end

  // round unit and schedule window
  assign w_cur = blk_q[511:480];
  assign w_new = sha256_pkg::small_sigma1(blk_q[63:32]) + blk_q[223:192]
               + sha256_pkg::small_sigma0(blk_q[479:448]) + blk_q[511:480];
  assign ch  = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1  = vars_q[7] + sha256_pkg::big_sigma1(vars_q[4]) + ch
             + sha256_pkg::round_k(round_q) + w_cur;
  assign t2  = sha256_pkg::big_sigma0(vars_q[0]) + maj;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    pad_act_d  = pad_act_q;
    pad_done_d = pad_done_q;
    fill_d     = fill_q;
    round_d    = round_q;
    idx_d      = idx_q;
    count_d    = count_q;
    hash_d     = hash_q;
    vars_d     = vars_q;
    blk_d      = blk_q;
    push       = 1'b0;
    push_byte  = 8'h00;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (end_of_message_i) begin
            pad_act_d = 1'b1;
            phase_d   = P_MARK;
            state_d   = S_PAD;
          end
          if (has_byte_i) begin
            push      = 1'b1;
            push_byte = message_byte_i;
            count_d   = count_q + 1'b1;
            if (fill_q == sha256_pkg::LastSlot) begin
              state_d = S_COMP;
            end
          end
        end
      end
      S_PAD: begin
        push      = 1'b1;
        push_byte = pad_byte;
        case (phase_q)
          P_MARK: begin
            if (fill_q < sha256_pkg::LenStart || fill_q == sha256_pkg::LastSlot) begin
              phase_d = P_ZERO_LEN;
            end else begin
              phase_d = P_ZERO_WRAP;
            end
          end
          P_ZERO_WRAP: begin
            if (fill_q == sha256_pkg::LastSlot) begin
              phase_d = P_ZERO_LEN;
            end
          end
          default: phase_d = phase_q;
        endcase
        if (fill_q == sha256_pkg::LastSlot) begin
          state_d = S_COMP;
          if (phase_q == P_ZERO_LEN) begin
            pad_done_d = 1'b1;
          end
        end
      end
      S_COMP: begin
        blk_d     = {blk_q[479:0], w_new};
        vars_d[7] = vars_q[6];
        vars_d[6] = vars_q[5];
        vars_d[5] = vars_q[4];
        vars_d[4] = vars_q[3] + t1;
        vars_d[3] = vars_q[2];
        vars_d[2] = vars_q[1];
        vars_d[1] = vars_q[0];
        vars_d[0] = t1 + t2;
        round_d   = round_q + 1'b1;
        if (round_q == sha256_pkg::LastRound) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        for (int i = 0; i < sha256_pkg::NumH; i++) begin
          hash_d[i] = hash_q[i] + vars_q[i];
        end
        if (pad_done_q) begin
          state_d = S_OUT;
          idx_d   = '0;
        end else if (pad_act_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          // shift the next word up and refill from the initial values
          for (int i = 0; i < sha256_pkg::NumH - 1; i++) begin
            hash_d[i] = hash_q[i+1];
          end
          hash_d[sha256_pkg::NumH-1] = sha256_pkg::init_h(idx_q);
          idx_d = idx_q + 1'b1;
          if (idx_q == 3'd7) begin
            state_d    = S_IDLE;
            count_d    = '0;
            pad_act_d  = 1'b0;
            pad_done_d = 1'b0;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (push) begin
      blk_d  = {blk_q[503:0], push_byte};
      fill_d = fill_q + 1'b1;
      if (fill_q == sha256_pkg::LastSlot) begin
        vars_d = hash_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= P_MARK;
      pad_act_q  <= 1'b0;
      pad_done_q <= 1'b0;
      fill_q     <= '0;
      round_q    <= '0;
      idx_q      <= '0;
      count_q    <= '0;
      hash_q     <= sha256_pkg::init_hash();
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      pad_act_q  <= pad_act_d;
      pad_done_q <= pad_done_d;
      fill_q     <= fill_d;
      round_q    <= round_d;
      idx_q      <= idx_d;
      count_q    <= count_d;
      hash_q     <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
    blk_q  <= blk_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign word_index_o  = idx_q;
  assign digest_word_o = hash_q[0];
  assign last_word_o   = (idx_q == 3'd7);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

  a_round_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_COMP) |-> (round_q == '0))
    else $error("round counter busy outside compression");

  a_comp_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP && round_q == sha256_pkg::LastRound) |=> (state_q == S_ADD))
    else $error("compression did not end after last round");

  a_fill_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (fill_q == '0 && pad_done_q))
    else $error("digest offered with a partial block");

  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_word_o)
    |=> (in_ready_o && hash_q == sha256_pkg::init_hash() && count_q == '0))
    else $error("state not restored after last digest word");

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench for sha256_message_hasher_unit. Byte streams are fed over the
// valid/ready input channel and a software SHA-256 in the scoreboard works out
// the eight digest words that each end of message must produce. The
// scoreboard compares every out transfer against the oldest predicted word.
// A directed run covers the empty message, ignored items, byte and end
// together, and the byte extremes. Random messages of mixed lengths follow,
// including the padding boundaries. Sender gaps and receiver stalls change
// from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned PHASE_ITEMS  = 50;

  localparam logic [0:7][31:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [0:63][31:0] SHA_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct packed {
    logic [2:0]         idx;
    sha256_pkg::word_t  word;
    logic               last_flag;
  } digest_beat_t;

  class digest_board;
    sha256_pkg::word_t chain[8];
    sha256_pkg::word_t blk[16];
    int unsigned       fill;
    logic [60:0]       msg_bytes;
    digest_beat_t      digest_due[$];
    int unsigned       fails;

    function new();
      fails = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = SHA_IV[i];
      fill      = 0;
      msg_bytes = '0;
    endfunction

    function sha256_pkg::word_t ror(sha256_pkg::word_t x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      sha256_pkg::word_t w[64];
      sha256_pkg::word_t v[8];
      sha256_pkg::word_t t1;
      sha256_pkg::word_t t2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 64; i++) begin
        w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
             + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void absorb(logic [7:0] b);
      if (fill % 4 == 0) blk[fill / 4] = '0;
      blk[fill / 4] = blk[fill / 4]
                    | (sha256_pkg::word_t'(b) << (8 * (3 - fill % 4)));
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    endfunction

    function void note_transfer(logic has, logic [7:0] b, logic eom);
      logic [63:0]  bit_len;
      digest_beat_t beat;
      if (has) begin
        msg_bytes = msg_bytes + 61'd1;
        absorb(b);
      end
      if (!eom) return;
      bit_len = {msg_bytes, 3'b000};
      absorb(sha256_pkg::PadMark);
      while (fill != sha256_pkg::LenStart) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(bit_len[63 - 8 * i -: 8]);
      for (int i = 0; i < 8; i++) begin
        beat.idx       = 3'(i);
        beat.word      = chain[i];
        beat.last_flag = (i == 7);
        digest_due.insert(digest_due.size(), beat);
      end
      restart();
    endfunction

    function void check_word(logic [2:0] idx, sha256_pkg::word_t word, logic last_flag);
      digest_beat_t due;
      if (digest_due.size() == 0) begin
        $display("%0t: digest word %0d = %08h with nothing expected", $time, idx, word);
        fails++;
        return;
      end
      due = digest_due.pop_front();
      if (idx !== due.idx) begin
        $display("%0t: word_index expected %0d actual %0d", $time, due.idx, idx);
        fails++;
      end
      if (word !== due.word) begin
        $display("%0t: digest_word[%0d] expected %08h actual %08h",
                 $time, due.idx, due.word, word);
        fails++;
      end
      if (last_flag !== due.last_flag) begin
        $display("%0t: last_word[%0d] expected %0b actual %0b",
                 $time, due.idx, due.last_flag, last_flag);
        fails++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              has_byte  = 1'b0;
  logic [7:0]        msg_byte  = 8'h00;
  logic              end_msg   = 1'b0;
  logic              out_ready = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [2:0]        word_index_o;
  sha256_pkg::word_t digest_word_o;
  logic              last_word_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned items_sent     = 0;
  int unsigned quiet_cycles   = 0;
  digest_board board = new();

  sha256_message_hasher_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .has_byte_i       (has_byte),
    .message_byte_i   (msg_byte),
    .end_of_message_i (end_msg),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .word_index_o     (word_index_o),
    .digest_word_o    (digest_word_o),
    .last_word_o      (last_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready_o) board.note_transfer(has_byte, msg_byte, end_msg);
    if (rst_ni && out_valid_o && out_ready) begin
      board.check_word(word_index_o, digest_word_o, last_word_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("** sha256_message_hasher_unit: FAILED **");
    $finish;
  end

  // returns at the edge of the transfer with valid still high
  task automatic send_item(logic has, logic [7:0] b, logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    has_byte <= has;
    msg_byte <= b;
    end_msg  <= eom;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_message(int unsigned len);
    logic       finish_alone;
    logic [7:0] b;
    finish_alone = (len == 0) || ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_item(1'b0, 8'($urandom), 1'b0);
      case ($urandom_range(11))
        0:       b = 8'h00;
        1:       b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_item(1'b1, b, (i == len - 1) && !finish_alone);
      items_sent++;
    end
    if (finish_alone) begin
      send_item(1'b0, 8'($urandom), 1'b1);
      items_sent++;
    end
  endtask

  task automatic drain_digests();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.digest_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_len();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(99);
    if (r < 55) begin
      len = $urandom_range(10);
    end else if (r < 80) begin
      len = $urandom_range(40, 11);
    end else if (r < 95) begin
      case ($urandom_range(3))
        0:       len = 55;
        1:       len = 56;
        2:       len = 63;
        default: len = 64;
      endcase
    end else begin
      len = $urandom_range(130, 100);
    end
    return len;
  endfunction

  initial begin
    int unsigned phase_start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, ignored item, "abc", byte with end, extremes
    send_item(1'b0, 8'h00, 1'b1);
    send_item(1'b0, 8'hff, 1'b0);
    send_item(1'b1, 8'h61, 1'b0);
    send_item(1'b1, 8'h62, 1'b0);
    send_item(1'b1, 8'h63, 1'b1);
    send_item(1'b1, 8'hff, 1'b1);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b0, 8'hff, 1'b0);
    send_item(1'b1, 8'h80, 1'b0);
    send_item(1'b1, 8'h7f, 1'b0);
    send_item(1'b0, 8'h00, 1'b1);
    drain_digests();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      phase_start = items_sent;
      // padding just fits, and padding that spills into a second block
      if (phase == 0) send_message(55);
      if (phase == 2) send_message(56);
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_message(pick_len());
        if ($urandom_range(5) == 0) drain_digests();
      end
      drain_digests();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.fails == 0 && board.digest_due.size() == 0) begin
      $display("** sha256_message_hasher_unit: PASSED **");
    end else begin
      $display("** sha256_message_hasher_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* sha256_message_hasher_unit.f */
rtl/sha256_pkg.sv
rtl/sha256_message_hasher_unit.sv
bench/tb_top.sv
